// ===== src/mtaf_pkg.sv =====
// ============================================================================
// mtaf_pkg
// Shared constants and types for the median-then-average filter.
// ============================================================================
`default_nettype none

package mtaf_pkg;

    // Configuration register widths and reset values
    localparam int THRESH_W   = 10;
    localparam int SERVO_W    = 8;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_INDEX_W = 1;

    localparam logic [THRESH_W-1:0] THRESH_RESET      = 10'd1;
    localparam logic [SERVO_W-1:0]  SERVO_LIMIT_RESET = 8'd254;

    // Servo position is the filtered value divided by four
    localparam int SERVO_SHIFT = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHANGE_THRESHOLD = 1'b0,
        CFG_SERVO_LIMIT      = 1'b1
    } cfg_index_t;

    // Load strobes for the averaging stages
    typedef struct packed {
        logic load_sum;
        logic load_product;
    } avg_ctrl_t;

endpackage

`default_nettype wire

// ===== src/mtaf_if.sv =====
// ============================================================================
// mtaf_if
// Valid/ready channels for converter samples and filter results.
// ============================================================================
`default_nettype none

interface mtaf_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface mtaf_out_if #(
    parameter int SAMPLE_BITS = 10
);
    import mtaf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] filtered_value;
    logic [SERVO_W-1:0]     servo_position;
    logic                   changed;

    modport source (output valid, output filtered_value, output servo_position,
                    output changed, input ready);
    modport sink   (input valid, input filtered_value, input servo_position,
                    input changed, output ready);
endinterface

`default_nettype wire

// ===== src/mtaf_median.sv =====
// ============================================================================
// mtaf_median
// Sample window shift line and rank-select median, registered result.
// ============================================================================
`default_nettype none

module mtaf_median #(
    parameter int MEDIAN_TAPS = 5,
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic      [SAMPLE_BITS-1:0] median
);
    localparam int RANK_W = $clog2(MEDIAN_TAPS);
    localparam logic [RANK_W-1:0] MED_RANK = RANK_W'((MEDIAN_TAPS - 1) / 2);

    logic [SAMPLE_BITS-1:0] win_reg  [MEDIAN_TAPS];
    logic [SAMPLE_BITS-1:0] win_next [MEDIAN_TAPS];
    logic [RANK_W-1:0]      rank     [MEDIAN_TAPS];
    logic [SAMPLE_BITS-1:0] median_reg;
    logic [SAMPLE_BITS-1:0] median_next;

    // Window order does not matter for the median, so a shift line serves
    always_comb
    begin
        win_next[0] = sample;
        for (int k = 1; k < MEDIAN_TAPS; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
    end

    // Rank of each entry; ties broken by position so exactly one hits MED_RANK
    always_comb
    begin
        for (int i = 0; i < MEDIAN_TAPS; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < MEDIAN_TAPS; j++)
            begin
                if (j != i)
                begin
                    if ((win_next[j] < win_next[i]) ||
                        ((win_next[j] == win_next[i]) && (j < i)))
                    begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end
            end
        end
        median_next = '0;
        for (int i = 0; i < MEDIAN_TAPS; i++)
        begin
            if (rank[i] == MED_RANK)
            begin
                median_next = median_next | win_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MEDIAN_TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (load)
        begin
            for (int k = 0; k < MEDIAN_TAPS; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            median_reg <= median_next;
        end
    end

    assign median = median_reg;

endmodule

`default_nettype wire

// ===== src/mtaf_average.sv =====
// ============================================================================
// mtaf_average
// Median window with running sum, then mean by reciprocal multiply.
// ============================================================================
`default_nettype none

module mtaf_average #(
    parameter int AVERAGE_TAPS = 8,
    parameter int SAMPLE_BITS  = 10
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mtaf_pkg::avg_ctrl_t       ctrl,
    input  wire logic [SAMPLE_BITS-1:0]    median,
    output logic      [SAMPLE_BITS-1:0]    mean
);
    import mtaf_pkg::*;

    localparam int TAP_BITS = $clog2(AVERAGE_TAPS);
    localparam int SUM_W    = SAMPLE_BITS + TAP_BITS;
    // floor(sum * RECIP >> SHIFT) is exact for every sum below 2**SUM_W
    localparam int SHIFT    = SUM_W + TAP_BITS;
    localparam int MUL_W    = SUM_W + 2;
    localparam int PROD_W   = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((64'd1 << SHIFT) + 64'(AVERAGE_TAPS) - 64'd1) / 64'(AVERAGE_TAPS));

    logic [SAMPLE_BITS-1:0] avg_reg [AVERAGE_TAPS];
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [PROD_W-1:0]      product_reg;

    assign sum_next = sum_reg + SUM_W'(median) - SUM_W'(avg_reg[AVERAGE_TAPS-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AVERAGE_TAPS; k++)
            begin
                avg_reg[k] <= '0;
            end
            sum_reg <= '0;
        end
        else if (ctrl.load_sum)
        begin
            avg_reg[0] <= median;
            for (int k = 1; k < AVERAGE_TAPS; k++)
            begin
                avg_reg[k] <= avg_reg[k-1];
            end
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_product)
        begin
            product_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP);
        end
    end

    assign mean = product_reg[SHIFT +: SAMPLE_BITS];

endmodule

`default_nettype wire

// ===== src/median_then_average_filter_top.sv =====
// ============================================================================
// median_then_average_filter_top
// Median-of-window then moving-average filter for one converter channel.
//
// Every sample transfer yields exactly one result transfer, in order. The
// block is a five-register pipeline (input, median, running sum, reciprocal
// product, result) and takes one sample per clock while the result side
// keeps up. Each stage has its own valid bit and passes its item on as
// soon as the next stage is free, so a stalled result does not hold up
// samples until all five stages are full. The median window
// (MEDIAN_TAPS) and the average window (AVERAGE_TAPS) start at zero
// after reset, so early outputs are pulled toward zero until both
// windows fill. The mean is truncated. The servo position is the mean
// divided by four, saturated at servo_limit. The changed flag is set
// when the mean differs from the last reported value by strictly more
// than change_threshold, and the reported value then follows the mean.
// Configuration writes (index 0 change_threshold, index 1 servo_limit)
// are meant for times when no item is in flight.
// ============================================================================
`default_nettype none

module median_then_average_filter_top #(
    parameter int MEDIAN_TAPS  = 5,
    parameter int AVERAGE_TAPS = 8,
    parameter int SAMPLE_BITS  = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    mtaf_in_if.sink                                samples,
    mtaf_out_if.source                             results,
    input  wire logic                              cfg_write_en,
    input  wire logic [mtaf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mtaf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mtaf_pkg::*;

    // Compare widths cover both the sample and the fixed register widths
    localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
    localparam int QUO_W = SAMPLE_BITS - SERVO_SHIFT;
    localparam int LIM_W = (QUO_W > SERVO_W) ? QUO_W : SERVO_W;

    // ---------------- configuration registers ----------------
    logic [THRESH_W-1:0] threshold_reg;
    logic [SERVO_W-1:0]  servo_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESH_RESET;
            servo_limit_reg <= SERVO_LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CHANGE_THRESHOLD: threshold_reg   <= cfg_data[THRESH_W-1:0];
                CFG_SERVO_LIMIT:      servo_limit_reg <= cfg_data[SERVO_W-1:0];
                default:              ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    // One valid bit per stage; a stage is free when empty or when its item
    // moves on in the same cycle.
    logic in_valid_reg, med_valid_reg, sum_valid_reg, prod_valid_reg, out_valid_reg;
    logic rdy_in, rdy_med, rdy_sum, rdy_prod, rdy_out;

    assign rdy_out  = !out_valid_reg  || results.ready;
    assign rdy_prod = !prod_valid_reg || rdy_out;
    assign rdy_sum  = !sum_valid_reg  || rdy_prod;
    assign rdy_med  = !med_valid_reg  || rdy_sum;
    assign rdy_in   = !in_valid_reg   || rdy_med;

    assign samples.ready = rdy_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            med_valid_reg  <= 1'b0;
            sum_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rdy_in)   in_valid_reg   <= samples.valid;
            if (rdy_med)  med_valid_reg  <= in_valid_reg;
            if (rdy_sum)  sum_valid_reg  <= med_valid_reg;
            if (rdy_prod) prod_valid_reg <= sum_valid_reg;
            if (rdy_out)  out_valid_reg  <= prod_valid_reg;
        end
    end

    // ---------------- input register ----------------
    logic [SAMPLE_BITS-1:0] sample_reg;

    always_ff @(posedge clk)
    begin
        if (rdy_in && samples.valid)
        begin
            sample_reg <= samples.adc_sample;
        end
    end

    // ---------------- median stage ----------------
    logic [SAMPLE_BITS-1:0] median;

    mtaf_median #(
        .MEDIAN_TAPS (MEDIAN_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_valid_reg && rdy_med),
        .sample (sample_reg),
        .median (median)
    );

    // ---------------- running sum and mean ----------------
    avg_ctrl_t              avg_ctrl;
    logic [SAMPLE_BITS-1:0] mean;

    assign avg_ctrl.load_sum     = med_valid_reg && rdy_sum;
    assign avg_ctrl.load_product = sum_valid_reg && rdy_prod;

    mtaf_average #(
        .AVERAGE_TAPS (AVERAGE_TAPS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_average (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (avg_ctrl),
        .median (median),
        .mean   (mean)
    );

    // ---------------- report stage ----------------
    logic [SAMPLE_BITS-1:0] filtered_reg;
    logic [SERVO_W-1:0]     servo_reg;
    logic                   changed_reg;
    logic [SAMPLE_BITS-1:0] last_reported_reg;

    logic [SAMPLE_BITS-1:0] diff;
    logic                   changed_next;
    logic [LIM_W-1:0]       quotient;
    logic [SERVO_W-1:0]     servo_next;
    logic                   report_load;

    assign report_load = prod_valid_reg && rdy_out;

    // Absolute distance from the last reported value
    assign diff = (mean > last_reported_reg) ? (mean - last_reported_reg)
                                             : (last_reported_reg - mean);
    assign changed_next = CMP_W'(diff) > CMP_W'(threshold_reg);

    // Saturate mean/4 at the servo limit
    assign quotient   = LIM_W'(mean[SAMPLE_BITS-1:SERVO_SHIFT]);
    assign servo_next = (quotient > LIM_W'(servo_limit_reg)) ? servo_limit_reg
                                                             : SERVO_W'(quotient);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reported_reg <= '0;
        end
        else if (report_load && changed_next)
        begin
            last_reported_reg <= mean;
        end
    end

    always_ff @(posedge clk)
    begin
        if (report_load)
        begin
            filtered_reg <= mean;
            servo_reg    <= servo_next;
            changed_reg  <= changed_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.filtered_value = filtered_reg;
    assign results.servo_position = servo_reg;
    assign results.changed        = changed_reg;

`ifndef SYNTHESIS
    // A waiting result that flagged a change has already moved the report point
    a_changed_tracks_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && changed_reg) |-> (last_reported_reg == filtered_reg))
        else $error("last reported value does not match flagged result");

    // Back-pressure reaches the sample side only with every stage occupied
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (in_valid_reg && med_valid_reg && sum_valid_reg &&
                            prod_valid_reg && out_valid_reg))
        else $error("sample side stalled with a free pipeline stage");

    // Servo position never exceeds the quarter of the filtered value
    a_servo_below_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (LIM_W'(servo_reg) <= LIM_W'(filtered_reg[SAMPLE_BITS-1:SERVO_SHIFT])))
        else $error("servo position above filtered value divided by four");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the median-then-average filter.
//
// Converter samples go in on a valid/ready channel in random bursts. Each
// accepted sample is run through a behavioral copy of the filter: a median
// ring, a mean ring, the servo clamp and the change detector. The expected
// result is queued and compared field by field with the next result
// transfer. The result side stalls on its own random pattern. At two points
// it also holds off for a long stretch so the pipeline fills and pushes
// back on the samples. Between phases the bench drains, then rewrites the
// threshold and the servo limit, extremes included.
// ============================================================================
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mtaf_pkg::*;

    localparam int MEDIAN_TAPS    = 5;
    localparam int AVERAGE_TAPS   = 8;
    localparam int SAMPLE_BITS    = 10;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;

    localparam int SETTLE_CYCLES  = 8;     // pipeline is five stages deep
    localparam int LONG_HOLD      = 80;    // long result-side hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] filtered_value;
        logic [SERVO_W-1:0]     servo_position;
        logic                   changed;
    } filter_result_t;

    typedef enum {
        SHAPE_NOISE,   // full-range random, every bit toggles
        SHAPE_DRIFT,   // slow wander with small jitter
        SHAPE_SPIKY    // drift with impulses to the rails
    } sample_shape_t;

    logic clk;
    logic rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mtaf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    mtaf_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

    median_then_average_filter_top #(
        .MEDIAN_TAPS  (MEDIAN_TAPS),
        .AVERAGE_TAPS (AVERAGE_TAPS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (sample_ch),
        .results      (result_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] samples_to_send[$];     // filled by the stimulus
    filter_result_t         filter_results_due[$];  // oldest first

    // Behavioral copy of the filter state and its two registers
    logic [SAMPLE_BITS-1:0] median_ring[MEDIAN_TAPS];
    logic [SAMPLE_BITS-1:0] mean_ring[AVERAGE_TAPS];
    int                     median_slot;
    int                     mean_slot;
    logic [SAMPLE_BITS-1:0] last_reported_value;
    logic [THRESH_W-1:0]    threshold_mirror;
    logic [SERVO_W-1:0]     servo_limit_mirror;

    logic sample_fire;       // sample transfer seen at the last rising edge
    int   error_count;
    int   idle_cycles;
    int   hold_requests;     // bumped by stimulus to ask for a long hold-off
    int   holds_served;
    int   burst_left;
    int   gap_left;
    int   ready_run_left;
    int   ready_stall_left;
    int   drift_level;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Filter prediction: one sample in, one result out, state advanced.
    // The median is the lower middle of the sorted ring; the mean truncates.
    // ------------------------------------------------------------------------
    task automatic filter_step(input logic [SAMPLE_BITS-1:0] sample,
                               output filter_result_t outcome);
        logic [SAMPLE_BITS-1:0] sorted[MEDIAN_TAPS];
        logic [SAMPLE_BITS-1:0] v;
        logic [SAMPLE_BITS-1:0] median;
        logic [SAMPLE_BITS-1:0] mean;
        logic [SAMPLE_BITS-1:0] quotient;
        logic [SAMPLE_BITS-1:0] diff;
        int unsigned            total;
        int                     a;
        int                     b;

        median_ring[median_slot] = sample;
        median_slot = (median_slot == MEDIAN_TAPS - 1) ? 0 : median_slot + 1;

        // insertion sort of the median ring
        for (a = 0; a < MEDIAN_TAPS; a++)
        begin
            v = median_ring[a];
            b = a;
            while (b > 0 && sorted[b - 1] > v)
            begin
                sorted[b] = sorted[b - 1];
                b--;
            end
            sorted[b] = v;
        end
        median = sorted[(MEDIAN_TAPS - 1) / 2];

        mean_ring[mean_slot] = median;
        mean_slot = (mean_slot == AVERAGE_TAPS - 1) ? 0 : mean_slot + 1;

        total = 0;
        for (a = 0; a < AVERAGE_TAPS; a++)
            total += mean_ring[a];
        mean = SAMPLE_BITS'(total / AVERAGE_TAPS);

        // servo clamps at the limit, a zero limit included
        quotient = mean >> SERVO_SHIFT;
        if (quotient > servo_limit_mirror)
            outcome.servo_position = servo_limit_mirror;
        else
            outcome.servo_position = SERVO_W'(quotient);

        // strictly greater than threshold counts as a change
        diff = (mean > last_reported_value) ? mean - last_reported_value
                                            : last_reported_value - mean;
        outcome.changed = (diff > threshold_mirror);
        if (outcome.changed)
            last_reported_value = mean;

        outcome.filtered_value = mean;
    endtask

    // ------------------------------------------------------------------------
    // Rising-edge sampling: register mirror, prediction, result checking and
    // the watchdog. All handshake signals are stable here since every input
    // moves on the falling edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sampler
        filter_result_t predicted;
        filter_result_t seen;
        filter_result_t wanted;
        logic           in_xfer;
        logic           out_xfer;

        if (!rst_n)
        begin
            for (int a = 0; a < MEDIAN_TAPS; a++)
                median_ring[a] = '0;
            for (int a = 0; a < AVERAGE_TAPS; a++)
                mean_ring[a] = '0;
            median_slot         = 0;
            mean_slot           = 0;
            last_reported_value = '0;
            threshold_mirror    = THRESH_RESET;
            servo_limit_mirror  = SERVO_LIMIT_RESET;
            idle_cycles         = 0;
            sample_fire        <= 1'b0;
        end
        else
        begin
            in_xfer  = sample_ch.valid && sample_ch.ready;
            out_xfer = result_ch.valid && result_ch.ready;

            // registers only get written while the pipeline is empty
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_CHANGE_THRESHOLD: threshold_mirror = cfg_data[THRESH_W-1:0];
                    CFG_SERVO_LIMIT:      servo_limit_mirror = cfg_data[SERVO_W-1:0];
                    default: ;
                endcase
            end

            // check the result before queuing a new prediction
            if (out_xfer)
            begin
                seen.filtered_value = result_ch.filtered_value;
                seen.servo_position = result_ch.servo_position;
                seen.changed        = result_ch.changed;
                if (filter_results_due.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected: fv=%0d sp=%0d ch=%0b",
                             $realtime, seen.filtered_value, seen.servo_position,
                             seen.changed);
                    error_count++;
                end
                else
                begin
                    wanted = filter_results_due.pop_front();
                    if (seen.filtered_value !== wanted.filtered_value)
                    begin
                        $display("%0t: filtered_value expected %0d got %0d",
                                 $realtime, wanted.filtered_value, seen.filtered_value);
                        error_count++;
                    end
                    if (seen.servo_position !== wanted.servo_position)
                    begin
                        $display("%0t: servo_position expected %0d got %0d",
                                 $realtime, wanted.servo_position, seen.servo_position);
                        error_count++;
                    end
                    if (seen.changed !== wanted.changed)
                    begin
                        $display("%0t: changed expected %0b got %0b",
                                 $realtime, wanted.changed, seen.changed);
                        error_count++;
                    end
                end
            end

            if (in_xfer)
            begin
                filter_step(sample_ch.adc_sample, predicted);
                filter_results_due.push_back(predicted);
            end
            sample_fire <= in_xfer;

            // watchdog: only counts stretches with no transfer on either side
            if (in_xfer || out_xfer)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sample driver: bursts of random length separated by random gaps. Holds
    // the current sample until it transfers. Half the gaps are zero, so long
    // gapless stretches show up as well.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : sample_driver
        logic                   next_valid;
        logic [SAMPLE_BITS-1:0] next_sample;

        if (rst_n && !(sample_ch.valid && !sample_fire))
        begin
            next_valid  = 1'b0;
            next_sample = sample_ch.adc_sample;
            if (gap_left > 0)
                gap_left--;
            else if (samples_to_send.size() > 0)
            begin
                next_valid  = 1'b1;
                next_sample = samples_to_send.pop_front();
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            sample_ch.valid      <= next_valid;
            sample_ch.adc_sample <= next_sample;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: alternating ready runs and stalls of random length,
    // plus a long hold-off whenever the stimulus asks for one.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : result_receiver
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (hold_requests != holds_served)
            begin
                holds_served++;
                ready_stall_left = LONG_HOLD;
            end
            if (ready_stall_left == 0 && ready_run_left == 0)
            begin
                ready_stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                ready_run_left   = $urandom_range(1, 30);
            end
            if (ready_stall_left > 0)
            begin
                ready_stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                ready_run_left--;
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [SAMPLE_BITS-1:0] to_sample(int level);
        if (level < 0)
            return '0;
        if (level > SAMPLE_MAX)
            return SAMPLE_BITS'(SAMPLE_MAX);
        return SAMPLE_BITS'(level);
    endfunction

    task automatic queue_samples(int count, sample_shape_t shape);
        int jitter;

        for (int i = 0; i < count; i++)
        begin
            drift_level = to_sample(drift_level + $urandom_range(0, 24) - 12);
            jitter      = $urandom_range(0, 6) - 3;
            case (shape)
                SHAPE_NOISE:
                    samples_to_send.push_back(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
                SHAPE_DRIFT:
                    samples_to_send.push_back(to_sample(drift_level + jitter));
                default:
                    if ($urandom_range(0, 3) == 0)
                        samples_to_send.push_back(($urandom_range(0, 1) == 0) ?
                            SAMPLE_BITS'(0) : SAMPLE_BITS'(SAMPLE_MAX));
                    else
                        samples_to_send.push_back(to_sample(drift_level + jitter));
            endcase
        end
    endtask

    // random part: chunks of random shape and length
    task automatic queue_mixed(int count);
        int chunk;

        while (count > 0)
        begin
            chunk = $urandom_range(10, 40);
            if (chunk > count)
                chunk = count;
            queue_samples(chunk, sample_shape_t'($urandom_range(0, 2)));
            count -= chunk;
        end
    endtask

    // sender pause: wait until every sample has transferred and every
    // expected result has come back, then let the pipeline settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (samples_to_send.size() != 0 || sample_ch.valid
               || filter_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t index, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        cfg_write_en         = 1'b0;
        cfg_index            = CFG_CHANGE_THRESHOLD;
        cfg_data             = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.adc_sample = '0;
        result_ch.ready      = 1'b0;
        error_count          = 0;
        hold_requests        = 0;
        holds_served         = 0;
        burst_left           = 0;
        gap_left             = 0;
        ready_run_left       = 0;
        ready_stall_left     = 0;
        drift_level          = SAMPLE_MAX / 2;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Reset settings (threshold 1, limit 254). Start-up from zero-filled
        // rings, single spikes that the median rejects, a full-scale run
        // that pushes the servo past its limit, then alternating bit patterns.
        samples_to_send.push_back(SAMPLE_BITS'(0));
        samples_to_send.push_back(SAMPLE_BITS'(SAMPLE_MAX));
        samples_to_send.push_back(SAMPLE_BITS'(0));
        samples_to_send.push_back(SAMPLE_BITS'(SAMPLE_MAX));
        samples_to_send.push_back(SAMPLE_BITS'(0));
        repeat (10) samples_to_send.push_back(SAMPLE_BITS'(SAMPLE_MAX));
        samples_to_send.push_back(SAMPLE_BITS'('h155));
        samples_to_send.push_back(SAMPLE_BITS'('h2AA));
        samples_to_send.push_back(SAMPLE_BITS'('h155));
        samples_to_send.push_back(SAMPLE_BITS'('h2AA));
        samples_to_send.push_back(SAMPLE_BITS'('h2AA));
        samples_to_send.push_back(SAMPLE_BITS'(1));
        samples_to_send.push_back(SAMPLE_BITS'(0));
        wait_drained();

        // Both registers at zero: servo pinned at zero, and a slow ramp gives
        // steps equal to the threshold (no change) next to steps above it.
        write_register(CFG_CHANGE_THRESHOLD, '0);
        write_register(CFG_SERVO_LIMIT, '0);
        for (int i = 0; i < 30; i++)
            samples_to_send.push_back(SAMPLE_BITS'(100 + i));
        queue_mixed(90);
        wait_drained();

        // Top of both ranges: the change flag can never rise
        write_register(CFG_CHANGE_THRESHOLD, CFG_DATA_W'(SAMPLE_MAX));
        write_register(CFG_SERVO_LIMIT, CFG_DATA_W'(255));
        queue_mixed(100);
        wait_drained();

        // Limit written with bits above its width set; only the low eight
        // bits count. A long hold-off on results while samples keep coming
        // fills the pipeline and backs up the sample side.
        write_register(CFG_CHANGE_THRESHOLD, CFG_DATA_W'(16));
        write_register(CFG_SERVO_LIMIT, CFG_DATA_W'('h3C0));
        queue_samples(60, SHAPE_NOISE);
        hold_requests++;
        queue_mixed(90);
        wait_drained();

        // Random settings, with a full drain in the middle of the traffic
        write_register(CFG_CHANGE_THRESHOLD, CFG_DATA_W'($urandom_range(0, SAMPLE_MAX)));
        write_register(CFG_SERVO_LIMIT, CFG_DATA_W'($urandom_range(0, SAMPLE_MAX)));
        queue_mixed(75);
        wait_drained();
        queue_mixed(75);
        wait_drained();

        // Small threshold, mid limit, one more long hold-off
        write_register(CFG_CHANGE_THRESHOLD, CFG_DATA_W'(2));
        write_register(CFG_SERVO_LIMIT, CFG_DATA_W'(127));
        hold_requests++;
        queue_mixed(110);
        wait_drained();

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
